// File: hdl/xxh_pkg.sv
// Package: constants, types and helpers for the XXH64 stream hasher.
`timescale 1ns / 1ps
package xxh_pkg;

    localparam int unsigned LEN_BITS = 64;

    localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
    localparam logic [63:0] PR12 = PR1 + PR2;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_LH,
        MUL_HL
    } t_mul_step;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BYTE,
        ST_LANE_A,
        ST_LANE_B,
        ST_CONV,
        ST_MRG_A,
        ST_MRG_B,
        ST_MRG_C,
        ST_LEN,
        ST_TAIL,
        ST_T8_A,
        ST_T8_B,
        ST_T8_C,
        ST_T4_A,
        ST_T4_B,
        ST_T1_A,
        ST_T1_B,
        ST_AV_A,
        ST_AV_B,
        ST_DONE
    } t_state;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] k);
        logic [63:0] r;
        case (k)
            2'd0:    r = s + PR12;
            2'd1:    r = s + PR2;
            2'd2:    r = s;
            default: r = s - PR1;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/xxh_mul64.sv
// Shared 64x64 low-half multiplier from one 32x32 multiplier, steps LL, LH, HL.
`timescale 1ns / 1ps
module xxh_mul64 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xxh_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [63:0]       o_prod
);
    import xxh_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    t_mul_step   r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_pp;

    always_comb begin
        case (r_step)
            MUL_LL: begin
                w_x = r_a[31:0];
                w_y = r_b[31:0];
            end
            MUL_LH: begin
                w_x = r_a[31:0];
                w_y = r_b[63:32];
            end
            default: begin
                w_x = r_a[63:32];
                w_y = r_b[31:0];
            end
        endcase
        w_pp = 64'(w_x) * 64'(w_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= MUL_LL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_busy <= 1'b1;
                r_step <= MUL_LL;
            end else if (r_busy) begin
                case (r_step)
                    MUL_LL: begin
                        r_acc  <= w_pp;
                        r_step <= MUL_LH;
                    end
                    MUL_LH: begin
                        r_acc[63:32] <= r_acc[63:32] + w_pp[31:0];
                        r_step       <= MUL_HL;
                    end
                    default: begin
                        r_acc[63:32] <= r_acc[63:32] + w_pp[31:0];
                        r_busy       <= 1'b0;
                        r_done       <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: hdl/xxh64_stream_hasher_top.sv
// Top level: streaming XXH64 hasher with byte-serial buffering and a shared multiplier.
`timescale 1ns / 1ps
// Words are taken one at a time while the sequencer is idle. A word with n valid bytes
// keeps the input stalled while its bytes are moved into the stripe buffer one at a time.
// Each completed 32-byte stripe adds four lane rounds of two multiplies. Every multiply
// goes through the one shared 32x32 multiplier in three partial products. The last word
// adds the finish: lane convergence if a full stripe was seen, the length, 8-byte tail
// steps, a 4-byte step, single tail bytes, and the avalanche and the output load.
// The hash waits in an output register; the next message can be buffered meanwhile.
// A new hash is held back only while the previous one is still stalled.
module xxh64_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);
    import xxh_pkg::*;

    t_state                r_state, n_state;
    logic [63:0]           r_seed, n_seed;
    logic [3:0][63:0]      r_acc, n_acc;
    logic [3:0][63:0]      r_buf, n_buf;
    logic [4:0]            r_bpos, n_bpos;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic                  r_seen, n_seen;
    logic [63:0]           r_h, n_h;
    logic [63:0]           r_t, n_t;
    logic [4:0]            r_p, n_p;
    logic [1:0]            r_k, n_k;
    logic [63:0]           r_word, n_word;
    logic [3:0]            r_left, n_left;
    logic                  r_last, n_last;
    logic                  r_issued, n_issued;
    logic                  r_out_valid, n_out_valid;
    logic [63:0]           r_hash, n_hash;

    t_mul_req    w_req;
    logic        w_mul_done;
    logic [63:0] w_prod;
    logic [3:0]  w_cnt;
    logic [63:0] w_rot;
    logic [7:0]  w_tail_byte;

    xxh_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= '0;
            r_acc[0]    <= lane_init(64'd0, 2'd0);
            r_acc[1]    <= lane_init(64'd0, 2'd1);
            r_acc[2]    <= lane_init(64'd0, 2'd2);
            r_acc[3]    <= lane_init(64'd0, 2'd3);
            r_bpos      <= '0;
            r_len       <= '0;
            r_seen      <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_hash      <= '0;
            r_k         <= '0;
            r_p         <= '0;
            r_left      <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seed      <= n_seed;
            r_acc       <= n_acc;
            r_bpos      <= n_bpos;
            r_len       <= n_len;
            r_seen      <= n_seen;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            r_k         <= n_k;
            r_p         <= n_p;
            r_left      <= n_left;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf  <= n_buf;
        r_h    <= n_h;
        r_t    <= n_t;
        r_word <= n_word;
    end

    assign w_cnt       = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    assign w_tail_byte = r_buf[r_p[4:3]][{r_p[2:0], 3'b000} +: 8];

    always_comb begin
        case (r_k)
            2'd0:    w_rot = rotl64(r_acc[0], 1);
            2'd1:    w_rot = rotl64(r_acc[1], 7);
            2'd2:    w_rot = rotl64(r_acc[2], 12);
            default: w_rot = rotl64(r_acc[3], 18);
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_acc       = r_acc;
        n_buf       = r_buf;
        n_bpos      = r_bpos;
        n_len       = r_len;
        n_seen      = r_seen;
        n_h         = r_h;
        n_t         = r_t;
        n_p         = r_p;
        n_k         = r_k;
        n_word      = r_word;
        n_left      = r_left;
        n_last      = r_last;
        n_issued    = r_issued;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && i_out_stall;
        w_req.start = 1'b0;
        w_req.a     = r_h;
        w_req.b     = PR1;
        o_in_stall  = (r_state != ST_IDLE);

        case (r_state)
            ST_LANE_A: begin
                w_req.a = r_buf[r_k];
                w_req.b = PR2;
            end
            ST_LANE_B: w_req.a = r_acc[r_k];
            ST_MRG_A: begin
                w_req.a = r_acc[r_k];
                w_req.b = PR2;
            end
            ST_MRG_B, ST_T8_B: w_req.a = r_t;
            ST_T8_A: begin
                w_req.a = r_buf[r_p[4:3]];
                w_req.b = PR2;
            end
            ST_T8_C: w_req.a = rotl64(r_h, 27);
            ST_T4_A: w_req.a = {32'd0, r_buf[r_p[4:3]][31:0]};
            ST_T4_B: begin
                w_req.a = rotl64(r_h, 23);
                w_req.b = PR2;
            end
            ST_T1_A: begin
                w_req.a = {56'd0, w_tail_byte};
                w_req.b = PR5;
            end
            ST_T1_B: w_req.a = rotl64(r_h, 11);
            ST_AV_A: begin
                w_req.a = r_h ^ (r_h >> 33);
                w_req.b = PR2;
            end
            ST_AV_B: begin
                w_req.a = r_h ^ (r_h >> 29);
                w_req.b = PR3;
            end
            default: ;
        endcase

        case (r_state)
            ST_LANE_A, ST_LANE_B, ST_MRG_A, ST_MRG_B, ST_MRG_C, ST_T8_A, ST_T8_B,
            ST_T8_C, ST_T4_A, ST_T4_B, ST_T1_A, ST_T1_B, ST_AV_A, ST_AV_B: begin
                w_req.start = !r_issued;
                if (!r_issued) begin
                    n_issued = 1'b1;
                end
                if (w_mul_done) begin
                    n_issued = 1'b0;
                end
            end
            default: ;
        endcase

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_word  = i_data_word;
                    n_left  = w_cnt;
                    n_last  = i_last;
                    n_len   = r_len + LEN_BITS'(w_cnt);
                    n_state = ST_BYTE;
                end
            end
            ST_BYTE: begin
                if (r_left == 4'd0) begin
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else if (r_seen) begin
                        n_k     = 2'd0;
                        n_state = ST_CONV;
                    end else begin
                        n_h     = r_seed + PR5;
                        n_state = ST_LEN;
                    end
                end else begin
                    n_buf[r_bpos[4:3]][{r_bpos[2:0], 3'b000} +: 8] = r_word[7:0];
                    n_word = r_word >> 8;
                    n_left = r_left - 4'd1;
                    n_bpos = r_bpos + 5'd1;
                    if (r_bpos == 5'd31) begin
                        n_seen  = 1'b1;
                        n_k     = 2'd0;
                        n_state = ST_LANE_A;
                    end
                end
            end
            ST_LANE_A: begin
                if (w_mul_done) begin
                    n_acc[r_k] = rotl64(r_acc[r_k] + w_prod, 31);
                    n_state    = ST_LANE_B;
                end
            end
            ST_LANE_B: begin
                if (w_mul_done) begin
                    n_acc[r_k] = w_prod;
                    n_k        = r_k + 2'd1;
                    n_state    = (r_k == 2'd3) ? ST_BYTE : ST_LANE_A;
                end
            end
            ST_CONV: begin
                n_h = ((r_k == 2'd0) ? 64'd0 : r_h) + w_rot;
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = ST_MRG_A;
                end
            end
            ST_MRG_A, ST_T8_A: begin
                if (w_mul_done) begin
                    n_t     = rotl64(w_prod, 31);
                    n_state = (r_state == ST_MRG_A) ? ST_MRG_B : ST_T8_B;
                end
            end
            ST_MRG_B, ST_T8_B: begin
                if (w_mul_done) begin
                    n_h     = r_h ^ w_prod;
                    n_state = (r_state == ST_MRG_B) ? ST_MRG_C : ST_T8_C;
                end
            end
            ST_MRG_C: begin
                if (w_mul_done) begin
                    n_h     = w_prod + PR4;
                    n_k     = r_k + 2'd1;
                    n_state = (r_k == 2'd3) ? ST_LEN : ST_MRG_A;
                end
            end
            ST_LEN: begin
                n_h     = r_h + 64'(r_len);
                n_p     = 5'd0;
                n_state = ST_TAIL;
            end
            ST_TAIL: begin
                if ({1'b0, r_p} + 6'd8 <= {1'b0, r_bpos}) begin
                    n_state = ST_T8_A;
                end else if ({1'b0, r_p} + 6'd4 <= {1'b0, r_bpos}) begin
                    n_state = ST_T4_A;
                end else if (r_p < r_bpos) begin
                    n_state = ST_T1_A;
                end else begin
                    n_state = ST_AV_A;
                end
            end
            ST_T8_C: begin
                if (w_mul_done) begin
                    n_h     = w_prod + PR4;
                    n_p     = r_p + 5'd8;
                    n_state = ST_TAIL;
                end
            end
            ST_T4_A, ST_T1_A: begin
                if (w_mul_done) begin
                    n_h     = r_h ^ w_prod;
                    n_state = (r_state == ST_T4_A) ? ST_T4_B : ST_T1_B;
                end
            end
            ST_T4_B: begin
                if (w_mul_done) begin
                    n_h     = w_prod + PR3;
                    n_p     = r_p + 5'd4;
                    n_state = ST_TAIL;
                end
            end
            ST_T1_B: begin
                if (w_mul_done) begin
                    n_h     = w_prod;
                    n_p     = r_p + 5'd1;
                    n_state = ST_TAIL;
                end
            end
            ST_AV_A: begin
                if (w_mul_done) begin
                    n_h     = w_prod;
                    n_state = ST_AV_B;
                end
            end
            ST_AV_B: begin
                if (w_mul_done) begin
                    n_h     = w_prod;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_hash      = r_h ^ (r_h >> 32);
                    n_out_valid = 1'b1;
                    n_acc[0]    = lane_init(r_seed, 2'd0);
                    n_acc[1]    = lane_init(r_seed, 2'd1);
                    n_acc[2]    = lane_init(r_seed, 2'd2);
                    n_acc[3]    = lane_init(r_seed, 2'd3);
                    n_bpos      = '0;
                    n_len       = '0;
                    n_seen      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_seed_we) begin
            n_seed   = i_seed_wdata;
            n_acc[0] = lane_init(i_seed_wdata, 2'd0);
            n_acc[1] = lane_init(i_seed_wdata, 2'd1);
            n_acc[2] = lane_init(i_seed_wdata, 2'd2);
            n_acc[3] = lane_init(i_seed_wdata, 2'd3);
            n_bpos   = '0;
            n_len    = '0;
            n_seen   = 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

`ifndef ASSERT_OFF
    a_done_requested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> r_issued)
        else $error("multiplier result without a request");
    a_idle_no_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_issued)
        else $error("multiply outstanding while idle");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_seed_we) |=> (r_state == ST_BYTE))
        else $error("accepted beat not buffered");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && !(r_out_valid && i_out_stall))
        |=> (o_out_valid && (r_bpos == 5'd0) && (r_len == '0) && !r_seen))
        else $error("hash emitted without message restart");
`endif

endmodule

// File: tb/xxh64_stream_hasher_top_test.sv
// Testbench for the XXH64 stream hasher: directed and random messages checked against a predictor.
`timescale 1ns / 1ps
module xxh64_stream_hasher_top_test;
    import xxh_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_seed_we;
    logic [63:0] i_seed_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_data_word;
    logic [3:0]  i_byte_count;
    logic        i_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_hash_value;

    xxh64_stream_hasher_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

    localparam int WATCHDOG_LIMIT = 20000;

    // predictor state
    logic [63:0] hs_seed;
    logic [63:0] hs_lane [4];
    logic [7:0]  hs_buf [32];
    int unsigned hs_fill;
    logic [63:0] hs_len;
    bit          hs_striped;

    logic [63:0] hash_q [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          words_sent;
    int          hashes_seen;
    int          idle_cycles;
    bit          timed_out;

    function automatic logic [63:0] rot(input logic [63:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (64 - n)));
    endfunction

    function automatic logic [63:0] rnd(input logic [63:0] acc, input logic [63:0] w);
        return rot(acc + w * PR2, 31) * PR1;
    endfunction

    function automatic logic [63:0] buf_le(input int p, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v |= 64'(hs_buf[p + i]) << (8 * i);
        return v;
    endfunction

    task automatic hs_restart();
        hs_lane[0] = hs_seed + PR1 + PR2;
        hs_lane[1] = hs_seed + PR2;
        hs_lane[2] = hs_seed;
        hs_lane[3] = hs_seed - PR1;
        hs_fill = 0;
        hs_len = '0;
        hs_striped = 0;
    endtask

    function automatic logic [63:0] hs_finish();
        logic [63:0] h;
        int p;
        p = 0;
        if (hs_striped) begin
            h = rot(hs_lane[0], 1) + rot(hs_lane[1], 7) + rot(hs_lane[2], 12)
                + rot(hs_lane[3], 18);
            for (int k = 0; k < 4; k++) h = (h ^ rnd(64'd0, hs_lane[k])) * PR1 + PR4;
        end else begin
            h = hs_seed + PR5;
        end
        h += hs_len;
        while (p + 8 <= hs_fill) begin
            h ^= rnd(64'd0, buf_le(p, 8));
            h = rot(h, 27) * PR1 + PR4;
            p += 8;
        end
        if (p + 4 <= hs_fill) begin
            h ^= buf_le(p, 4) * PR1;
            h = rot(h, 23) * PR2 + PR3;
            p += 4;
        end
        while (p < hs_fill) begin
            h ^= 64'(hs_buf[p]) * PR5;
            h = rot(h, 11) * PR1;
            p++;
        end
        h ^= h >> 33;
        h *= PR2;
        h ^= h >> 29;
        h *= PR3;
        h ^= h >> 32;
        return h;
    endfunction

    task automatic hs_absorb(input logic [63:0] w, input logic [3:0] bc, input bit lst);
        int n;
        n = (bc > 4'd8) ? 8 : int'(bc);
        for (int i = 0; i < n; i++) begin
            hs_buf[hs_fill] = w[8 * i +: 8];
            hs_fill++;
            if (hs_fill == 32) begin
                for (int k = 0; k < 4; k++) hs_lane[k] = rnd(hs_lane[k], buf_le(8 * k, 8));
                hs_striped = 1;
                hs_fill = 0;
            end
        end
        hs_len += 64'(n);
        if (lst) begin
            hash_q.push_back(hs_finish());
            hs_restart();
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall and result check
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            hashes_seen++;
            if (hash_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected hash %h", o_hash_value);
            end else begin
                logic [63:0] exp_h;
                exp_h = hash_q.pop_front();
                if (exp_h !== o_hash_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hash mismatch: expected %h actual %h", exp_h, o_hash_value);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("[xxh64_stream_hasher_top] ERROR");
            $finish;
        end
    end

    // valid stays high after the accepting edge only until the next driver call
    // in the same time step replaces or drops it
    task automatic send_word(input logic [63:0] w, input logic [3:0] bc, input bit lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1;
        i_data_word  <= w;
        i_byte_count <= bc;
        i_last       <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        hs_absorb(w, bc, lst);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (hash_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        drain();
        i_seed_we    <= 1;
        i_seed_wdata <= s;
        @(posedge i_clk);
        i_seed_we <= 0;
        hs_seed = s;
        hs_restart();
    endtask

    function automatic logic [63:0] rword();
        return {$urandom, $urandom};
    endfunction

    task automatic send_message(input int nbytes);
        int left;
        left = nbytes;
        while (left > 8) begin
            send_word(rword(), 4'd8, 1'b0);
            left -= 8;
        end
        send_word(rword(), 4'(left), 1'b1);
    endtask

    task automatic test_directed();
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        send_word(64'h0, 4'd8, 1'b1);
        send_word(64'h0123_4567_89AB_CDEF, 4'd4, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send_word(64'hA5A5_5A5A_C3C3_3C3C, 4'd9, 1'b1);
        send_word(64'h1122_3344_5566_7788, 4'd3, 1'b0);
        send_word(64'h99AA_BBCC_DDEE_FF00, 4'd0, 1'b0);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b0);
        send_word(64'h0, 4'd0, 1'b1);
        for (int i = 0; i < 4; i++) send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_word(64'h0, 4'd0, 1'b1);
        for (int i = 0; i < 5; i++) send_word(64'h5555_AAAA_5555_AAAA, 4'd8, 1'b0);
        send_word(64'hDEAD_BEEF_0BAD_F00D, 4'd7, 1'b1);
    endtask

    task automatic test_seed_abort();
        send_word(rword(), 4'd8, 1'b0);
        send_word(rword(), 4'd5, 1'b0);
        drain();
        write_seed(64'h0123_4567_89AB_CDEF);
        send_word(rword(), 4'd6, 1'b1);
    endtask

    task automatic test_random(input int nwords);
        int start;
        start = words_sent;
        while (words_sent - start < nwords) begin
            case ($urandom_range(9))
                0: send_word(rword(), 4'($urandom_range(15)), 1'($urandom_range(1)));
                1: send_message($urandom_range(33, 100));
                2: send_word(rword(), 4'($urandom_range(8)), 1'b0);
                default: send_message($urandom_range(0, 40));
            endcase
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_seed_we = 0;
        i_seed_wdata = '0;
        i_in_valid = 0;
        i_data_word = '0;
        i_byte_count = '0;
        i_last = 0;
        i_out_stall = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        words_sent = 0;
        hashes_seen = 0;
        idle_cycles = 0;
        hs_seed = '0;
        hs_restart();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_directed();
        test_seed_abort();
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        test_directed();
        send_idle_pct = 49;
        write_seed({$urandom, $urandom});
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 49;
        write_seed(64'h0);
        test_random(100);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        write_seed({$urandom, $urandom});
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(60);
        drain();

        $display("sent %0d words, checked %0d hashes across five seeds", words_sent,
                 hashes_seen);
        $display("idle and stall phases: none, sender 49%%, receiver 49%%, both 31%%");
        if (mismatches == 0 && hash_q.size() == 0) begin
            $display("[xxh64_stream_hasher_top] OK");
        end else begin
            $display("%0d mismatches, %0d hashes missing", mismatches, hash_q.size());
            $display("[xxh64_stream_hasher_top] ERROR");
        end
        $finish;
    end
endmodule
